[rtl/pau_pkg.sv]
`timescale 1ns / 1ps
// phasor arithmetic unit package: codes, types, constants and shared functions
package pau_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int FRACTION_BITS = 16;
   localparam int GUARD_BITS = 2;
   localparam int GAIN_Q = 28;
   localparam int GAIN_W = 29;
   localparam int CORDIC_W = 38;
   localparam int ANGLE_W = 33;
   localparam int DIV_BITS = 32 + FRACTION_BITS;

   localparam int ROT_LAT = CORDIC_STAGES + 1;
   localparam int VEC_LAT = CORDIC_STAGES + 3;
   localparam int CORDIC_LAT = ROT_LAT + 1 + VEC_LAT;
   localparam int DIV_LAT = DIV_BITS + 1;
   localparam int SCALE_LAT = 1;
   localparam int ALIGN_LAT = ((CORDIC_LAT > DIV_LAT) ? CORDIC_LAT : DIV_LAT) + 1;
   localparam int OUT_LAT = ALIGN_LAT + 2;

   localparam logic [2:0] CMD_NORM = 3'd0;
   localparam logic [2:0] CMD_ADD = 3'd1;
   localparam logic [2:0] CMD_SUB = 3'd2;
   localparam logic [2:0] CMD_SCALE = 3'd3;
   localparam logic [2:0] CMD_DIV = 3'd4;
   localparam logic [2:0] CMD_NEG = 3'd5;
   localparam logic [2:0] CMD_RECIP = 3'd6;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_DIV0 = 2'd2;

   localparam logic [30:0] AMP_MAX = '1;
   localparam logic [15:0] HALF_TURN = 16'h8000;

   typedef struct packed {
      logic [30:0] amp;
      logic [30:0] freq;
      logic [15:0] ph;
   } phasor_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  cmd;
      logic [30:0] amp;
      logic [30:0] freq;
      logic [15:0] ph;
      logic        sneg;
      logic [1:0]  status;
   } sb_type;

   function automatic logic [31:0] atan_f(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0: r = 32'h20000000;
         5'd1: r = 32'h12E4051E;
         5'd2: r = 32'h09FB385B;
         5'd3: r = 32'h051111D4;
         5'd4: r = 32'h028B0D43;
         5'd5: r = 32'h0145D7E1;
         5'd6: r = 32'h00A2F61E;
         5'd7: r = 32'h00517C55;
         5'd8: r = 32'h0028BE53;
         5'd9: r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // 1/K^2 in q28, g -= g / (4^i + 1) per stage; later terms are zero
   localparam logic [63:0] IG_0 = 64'd1 << GAIN_Q;
   localparam logic [63:0] IG_1 = (CORDIC_STAGES > 0) ? IG_0 - IG_0 / 64'd2 : IG_0;
   localparam logic [63:0] IG_2 = (CORDIC_STAGES > 1) ? IG_1 - IG_1 / 64'd5 : IG_1;
   localparam logic [63:0] IG_3 = (CORDIC_STAGES > 2) ? IG_2 - IG_2 / 64'd17 : IG_2;
   localparam logic [63:0] IG_4 = (CORDIC_STAGES > 3) ? IG_3 - IG_3 / 64'd65 : IG_3;
   localparam logic [63:0] IG_5 = (CORDIC_STAGES > 4) ? IG_4 - IG_4 / 64'd257 : IG_4;
   localparam logic [63:0] IG_6 = (CORDIC_STAGES > 5) ? IG_5 - IG_5 / 64'd1025 : IG_5;
   localparam logic [63:0] IG_7 = (CORDIC_STAGES > 6) ? IG_6 - IG_6 / 64'd4097 : IG_6;
   localparam logic [63:0] IG_8 = (CORDIC_STAGES > 7) ? IG_7 - IG_7 / 64'd16385 : IG_7;
   localparam logic [63:0] IG_9 = (CORDIC_STAGES > 8) ? IG_8 - IG_8 / 64'd65537 : IG_8;
   localparam logic [63:0] IG_10 = (CORDIC_STAGES > 9) ? IG_9 - IG_9 / 64'd262145 : IG_9;
   localparam logic [63:0] IG_11 = (CORDIC_STAGES > 10) ? IG_10 - IG_10 / 64'd1048577 : IG_10;
   localparam logic [63:0] IG_12 = (CORDIC_STAGES > 11) ? IG_11 - IG_11 / 64'd4194305 : IG_11;
   localparam logic [63:0] IG_13 = (CORDIC_STAGES > 12) ? IG_12 - IG_12 / 64'd16777217 : IG_12;
   localparam logic [63:0] IG_14 = (CORDIC_STAGES > 13) ? IG_13 - IG_13 / 64'd67108865 : IG_13;

   localparam logic [GAIN_W-1:0] INV_GAIN2 = IG_14[GAIN_W-1:0];

   function automatic logic [30:0] sat31_f(input logic [63:0] v);
      return (v > 64'(AMP_MAX)) ? AMP_MAX : v[30:0];
   endfunction

   function automatic phasor_type norm_f(input logic signed [31:0] amp,
                                         input logic signed [31:0] freq,
                                         input logic [15:0] ph);
      phasor_type  r;
      logic [32:0] am;
      logic [32:0] fm;
      logic [15:0] p;
      p = ph;
      am = {amp[31], amp};
      fm = {freq[31], freq};
      if (amp[31]) begin
         am = -am;
         p = p + HALF_TURN;
      end
      if (freq[31]) begin
         fm = -fm;
         p = HALF_TURN - p;
      end
      r.amp = (am > 33'(AMP_MAX)) ? AMP_MAX : am[30:0];
      r.freq = (fm > 33'(AMP_MAX)) ? AMP_MAX : fm[30:0];
      r.ph = p;
      return r;
   endfunction

endpackage

[rtl/pau_cordic_rot.sv]
`timescale 1ns / 1ps
// pipelined cordic rotation, polar to rectangular
module pau_cordic_rot (
   input  logic                                  clock,
   input  logic [30:0]                           amp,
   input  logic signed [15:0]                    phase,
   output logic signed [pau_pkg::CORDIC_W-1:0]   x,
   output logic signed [pau_pkg::CORDIC_W-1:0]   y
);

   localparam int CS = pau_pkg::CORDIC_STAGES;
   localparam int CW = pau_pkg::CORDIC_W;
   localparam int TW = pau_pkg::ANGLE_W;

   logic signed [CW-1:0] x_ff [0:CS];
   logic signed [CW-1:0] y_ff [0:CS];
   logic signed [TW-1:0] t_ff [0:CS];
   logic signed [CW-1:0] x_in [0:CS];
   logic signed [CW-1:0] y_in [0:CS];
   logic signed [TW-1:0] t_in [0:CS];

   // quadrant fold
   always_comb begin
      logic signed [16:0]    p;
      logic signed [CW-1:0]  xs;
      p = {phase[15], phase};
      xs = CW'({amp, {pau_pkg::GUARD_BITS{1'b0}}});
      if (phase > 16'sd16384) begin
         p = p - 17'sd32768;
         xs = -xs;
      end else if (phase < -16'sd16384) begin
         p = p + 17'sd32768;
         xs = -xs;
      end
      x_in[0] = xs;
      y_in[0] = '0;
      t_in[0] = {p, 16'b0};
   end

   for (genvar i = 0; i < CS; i++) begin : g_stage
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [TW-1:0] at;
      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;
      assign at = TW'(pau_pkg::atan_f(5'(i)));
      always_comb begin
         if (!t_ff[i][TW-1]) begin
            x_in[i+1] = x_ff[i] - dy;
            y_in[i+1] = y_ff[i] + dx;
            t_in[i+1] = t_ff[i] - at;
         end else begin
            x_in[i+1] = x_ff[i] + dy;
            y_in[i+1] = y_ff[i] - dx;
            t_in[i+1] = t_ff[i] + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      t_ff <= t_in;
   end

   assign x = x_ff[CS];
   assign y = y_ff[CS];

endmodule

[rtl/pau_cordic_vec.sv]
`timescale 1ns / 1ps
// pipelined cordic vectoring with gain correction, rectangular to polar
module pau_cordic_vec (
   input  logic                                  clock,
   input  logic signed [pau_pkg::CORDIC_W-1:0]   x,
   input  logic signed [pau_pkg::CORDIC_W-1:0]   y,
   output logic [30:0]                           amp,
   output logic [15:0]                           phase
);

   localparam int CS = pau_pkg::CORDIC_STAGES;
   localparam int CW = pau_pkg::CORDIC_W;
   localparam int LOW_W = CW / 2;
   localparam int HIGH_W = CW - LOW_W;
   localparam int PW = HIGH_W + pau_pkg::GAIN_W;
   localparam int SW = PW + LOW_W + 1;
   localparam int SHIFT = pau_pkg::GAIN_Q + pau_pkg::GUARD_BITS;

   logic signed [CW-1:0] x_ff [0:CS];
   logic signed [CW-1:0] y_ff [0:CS];
   logic [31:0]          z_ff [0:CS];
   logic                 zero_ff [0:CS];
   logic signed [CW-1:0] x_in [0:CS];
   logic signed [CW-1:0] y_in [0:CS];
   logic [31:0]          z_in [0:CS];
   logic                 zero_in [0:CS];

   logic [PW-1:0] plo_ff, phi_ff, plo_in, phi_in;
   logic [31:0]   zg_ff;
   logic          zrg_ff;
   logic [30:0]   amp_ff, amp_in;
   logic [15:0]   ph_ff, ph_in;

   always_comb begin
      zero_in[0] = (x == '0) && (y == '0);
      if (x[CW-1]) begin
         x_in[0] = -x;
         y_in[0] = -y;
         z_in[0] = 32'h8000_0000;
      end else begin
         x_in[0] = x;
         y_in[0] = y;
         z_in[0] = '0;
      end
   end

   for (genvar i = 0; i < CS; i++) begin : g_stage
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic [31:0]          at;
      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;
      assign at = pau_pkg::atan_f(5'(i));
      always_comb begin
         zero_in[i+1] = zero_ff[i];
         if (!y_ff[i][CW-1]) begin
            x_in[i+1] = x_ff[i] + dy;
            y_in[i+1] = y_ff[i] - dx;
            z_in[i+1] = z_ff[i] + at;
         end else begin
            x_in[i+1] = x_ff[i] - dy;
            y_in[i+1] = y_ff[i] + dx;
            z_in[i+1] = z_ff[i] - at;
         end
      end
   end

   // gain correction split in two partial products
   assign plo_in = PW'(x_ff[CS][LOW_W-1:0]) * PW'(pau_pkg::INV_GAIN2);
   assign phi_in = PW'(x_ff[CS][CW-1:LOW_W]) * PW'(pau_pkg::INV_GAIN2);

   always_comb begin
      logic [SW-1:0] sum;
      logic [31:0]   zr;
      sum = {1'b0, phi_ff, LOW_W'(0)} + SW'(plo_ff) + (SW'(1) << (SHIFT - 1));
      zr = zg_ff + 32'h0000_8000;
      amp_in = pau_pkg::sat31_f(64'(sum >> SHIFT));
      ph_in = zr[31:16];
      if (zrg_ff) begin
         amp_in = '0;
         ph_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      zero_ff <= zero_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      zg_ff <= z_ff[CS];
      zrg_ff <= zero_ff[CS];
      amp_ff <= amp_in;
      ph_ff <= ph_in;
   end

   assign amp = amp_ff;
   assign phase = ph_ff;

endmodule

[rtl/pau_div.sv]
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
module pau_div (
   input  logic                           clock,
   input  logic [pau_pkg::DIV_BITS-1:0]   dividend,
   input  logic [31:0]                    divisor,
   output logic [pau_pkg::DIV_BITS-1:0]   quotient
);

   localparam int NB = pau_pkg::DIV_BITS;

   logic [NB-1:0] w_ff [0:NB];
   logic [31:0]   r_ff [0:NB];
   logic [31:0]   d_ff [0:NB];
   logic [NB-1:0] w_in [0:NB];
   logic [31:0]   r_in [0:NB];
   logic [31:0]   d_in [0:NB];

   assign w_in[0] = dividend;
   assign r_in[0] = '0;
   assign d_in[0] = divisor;

   for (genvar k = 0; k < NB; k++) begin : g_stage
      logic [32:0] trial;
      logic        ge;
      assign trial = {r_ff[k], w_ff[k][NB-1]};
      assign ge = trial >= {1'b0, d_ff[k]};
      assign r_in[k+1] = ge ? 32'(trial - {1'b0, d_ff[k]}) : trial[31:0];
      assign w_in[k+1] = {w_ff[k][NB-2:0], ge};
      assign d_in[k+1] = d_ff[k];
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign quotient = w_ff[NB];

endmodule

[rtl/phasor_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// phasor arithmetic unit top level: operand normalize, unit pipelines, result select
// result strobe: its delay is set by the 48-stage divider; the cordic chain is padded to match
// throughput: one item per cycle, every command; busy is high only during reset
// reset: synchronous, clears the valid bits of every stage; results cannot be held off
module phasor_arithmetic_unit_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_amp_a,
   input  logic signed [31:0] req_freq_a,
   input  logic signed [15:0] req_phase_a,
   input  logic signed [31:0] req_amp_b,
   input  logic signed [31:0] req_freq_b,
   input  logic signed [15:0] req_phase_b,
   input  logic signed [31:0] req_scalar,
   output logic               rsp_valid,
   output logic [30:0]        rsp_amp_out,
   output logic [30:0]        rsp_freq_out,
   output logic signed [15:0] rsp_phase_out,
   output logic [1:0]         rsp_status
);

   localparam int AL = pau_pkg::ALIGN_LAT;
   localparam int CW = pau_pkg::CORDIC_W;
   localparam int NB = pau_pkg::DIV_BITS;
   localparam int FB = pau_pkg::FRACTION_BITS;
   localparam int CPAD = AL - pau_pkg::CORDIC_LAT;
   localparam int SPAD = AL - pau_pkg::SCALE_LAT;
   localparam int DPAD = AL - pau_pkg::DIV_LAT;

   pau_pkg::sb_type s1_ff, s1_in;
   logic [30:0]     b_amp_ff, b_amp_in;
   logic [15:0]     b_ph_ff, b_ph_in;
   logic [31:0]     sabs_ff, sabs_in;
   pau_pkg::sb_type sb_ff [0:AL-1];

   assign busy = reset;

   always_comb begin
      pau_pkg::phasor_type a;
      pau_pkg::phasor_type b;
      a = pau_pkg::norm_f(req_amp_a, req_freq_a, req_phase_a);
      b = pau_pkg::norm_f(req_amp_b, req_freq_b, req_phase_b);
      sabs_in = req_scalar[31] ? 32'(-req_scalar) : req_scalar;
      b_amp_in = b.amp;
      b_ph_in = b.ph;
      s1_in.valid = start && !busy;
      s1_in.cmd = req_cmd;
      s1_in.amp = a.amp;
      s1_in.freq = a.freq;
      s1_in.ph = a.ph;
      s1_in.sneg = req_scalar[31];
      s1_in.status = pau_pkg::STATUS_OK;
      case (req_cmd) inside
         pau_pkg::CMD_ADD, pau_pkg::CMD_SUB: begin
            if (a.freq != b.freq) s1_in.status = pau_pkg::STATUS_MISMATCH;
         end
         pau_pkg::CMD_DIV: begin
            if (sabs_in == '0) s1_in.status = pau_pkg::STATUS_DIV0;
         end
         pau_pkg::CMD_RECIP: begin
            if (a.amp == '0) s1_in.status = pau_pkg::STATUS_DIV0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
      end
      b_amp_ff <= b_amp_in;
      b_ph_ff <= b_ph_in;
      sabs_ff <= sabs_in;
   end

   // item sideband line
   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff[0].valid <= 1'b0;
      end else begin
         sb_ff[0] <= s1_ff;
      end
   end

   for (genvar k = 1; k < AL; k++) begin : g_sb
      always_ff @(posedge clock) begin
         if (reset) begin
            sb_ff[k].valid <= 1'b0;
         end else begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   // add and subtract path
   logic signed [CW-1:0] xa, ya, xb, yb;
   logic signed [CW-1:0] xs_ff, ys_ff, xs_in, ys_in;
   logic [30:0]          vec_amp;
   logic [15:0]          vec_ph;

   pau_cordic_rot u_rot_a (
      .clock (clock),
      .amp   (s1_ff.amp),
      .phase (s1_ff.ph),
      .x     (xa),
      .y     (ya)
   );

   pau_cordic_rot u_rot_b (
      .clock (clock),
      .amp   (b_amp_ff),
      .phase (b_ph_ff),
      .x     (xb),
      .y     (yb)
   );

   always_comb begin
      if (sb_ff[pau_pkg::ROT_LAT-1].cmd == pau_pkg::CMD_SUB) begin
         xs_in = xa - xb;
         ys_in = ya - yb;
      end else begin
         xs_in = xa + xb;
         ys_in = ya + yb;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff <= xs_in;
      ys_ff <= ys_in;
   end

   pau_cordic_vec u_vec (
      .clock (clock),
      .x     (xs_ff),
      .y     (ys_ff),
      .amp   (vec_amp),
      .phase (vec_ph)
   );

   logic [30:0] cpa_ff [0:CPAD-1];
   logic [15:0] cph_ff [0:CPAD-1];

   always_ff @(posedge clock) begin
      cpa_ff[0] <= vec_amp;
      cph_ff[0] <= vec_ph;
   end

   for (genvar k = 1; k < CPAD; k++) begin : g_cpad
      always_ff @(posedge clock) begin
         cpa_ff[k] <= cpa_ff[k-1];
         cph_ff[k] <= cph_ff[k-1];
      end
   end

   // scale path
   logic [46:0] plo_ff, phi_ff, plo_in, phi_in;
   logic [30:0] spa_ff [0:SPAD-1];
   logic [63:0] sprod;

   assign plo_in = 47'(s1_ff.amp) * 47'(sabs_ff[15:0]);
   assign phi_in = 47'(s1_ff.amp) * 47'(sabs_ff[31:16]);
   assign sprod = 64'({phi_ff, 16'b0}) + 64'(plo_ff);

   always_ff @(posedge clock) begin
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      spa_ff[0] <= pau_pkg::sat31_f(sprod >> FB);
   end

   for (genvar k = 1; k < SPAD; k++) begin : g_spad
      always_ff @(posedge clock) begin
         spa_ff[k] <= spa_ff[k-1];
      end
   end

   // divide and scalar over amplitude path
   logic [NB-1:0] div_num, div_quo;
   logic [31:0]   div_den;
   logic [30:0]   dpa_ff [0:DPAD-1];

   assign div_num = (s1_ff.cmd == pau_pkg::CMD_RECIP) ?
                    {sabs_ff, {FB{1'b0}}} : {1'b0, s1_ff.amp, {FB{1'b0}}};
   assign div_den = (s1_ff.cmd == pau_pkg::CMD_RECIP) ? {1'b0, s1_ff.amp} : sabs_ff;

   pau_div u_div (
      .clock    (clock),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      dpa_ff[0] <= pau_pkg::sat31_f(64'(div_quo));
   end

   for (genvar k = 1; k < DPAD; k++) begin : g_dpad
      always_ff @(posedge clock) begin
         dpa_ff[k] <= dpa_ff[k-1];
      end
   end

   // result select
   pau_pkg::sb_type sb;
   logic [30:0]     amp_in, freq_in, spa, dpa;
   logic [15:0]     ph_in;
   logic [1:0]      status_in;
   logic            rsp_valid_ff;
   logic [30:0]     rsp_amp_ff, rsp_freq_ff;
   logic [15:0]     rsp_ph_ff;
   logic [1:0]      rsp_status_ff;

   assign sb = sb_ff[AL-1];
   assign spa = spa_ff[SPAD-1];
   assign dpa = dpa_ff[DPAD-1];

   always_comb begin
      amp_in = sb.amp;
      freq_in = sb.freq;
      ph_in = sb.ph;
      status_in = sb.status;
      case (sb.cmd) inside
         pau_pkg::CMD_ADD, pau_pkg::CMD_SUB: begin
            amp_in = cpa_ff[CPAD-1];
            ph_in = cph_ff[CPAD-1];
         end
         pau_pkg::CMD_SCALE: begin
            amp_in = spa;
            if (sb.sneg && spa != '0) ph_in = sb.ph + pau_pkg::HALF_TURN;
         end
         pau_pkg::CMD_DIV, pau_pkg::CMD_RECIP: begin
            amp_in = dpa;
            if (sb.sneg && dpa != '0) ph_in = sb.ph + pau_pkg::HALF_TURN;
         end
         pau_pkg::CMD_NEG: begin
            if (sb.amp != '0) ph_in = sb.ph + pau_pkg::HALF_TURN;
         end
         default: ;
      endcase
      if (sb.status != pau_pkg::STATUS_OK) begin
         amp_in = '0;
         freq_in = '0;
         ph_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sb.valid;
      end
      rsp_amp_ff <= amp_in;
      rsp_freq_ff <= freq_in;
      rsp_ph_ff <= ph_in;
      rsp_status_ff <= status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_amp_out = rsp_amp_ff;
   assign rsp_freq_out = rsp_freq_ff;
   assign rsp_phase_out = rsp_ph_ff;
   assign rsp_status = rsp_status_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start && !busy, pau_pkg::OUT_LAT))
      else $error("result strobe without matching accepted item");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != pau_pkg::STATUS_OK |->
         rsp_amp_ff == '0 && rsp_freq_ff == '0 && rsp_ph_ff == '0)
      else $error("error result with nonzero fields");

   a_mismatch_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == pau_pkg::STATUS_MISMATCH |->
         $past(req_cmd == pau_pkg::CMD_ADD || req_cmd == pau_pkg::CMD_SUB, pau_pkg::OUT_LAT))
      else $error("frequency mismatch on a command other than add or sub");

endmodule
